// ===== rtl/bdp_pkg.sv =====
`default_nettype none

package bdp_pkg;

  // Field widths of the request and response.
  localparam int unsigned AddrBits     = 32;
  localparam int unsigned OutCountBits = 32;

  // Predictor geometry.
  localparam int unsigned HistBits   = 10;
  localparam int unsigned CtrIdxBits = 10;  // 1024 counters per table
  localparam int unsigned LocIdxBits = 10;  // 1024 local histories
  localparam int unsigned CtrBits    = 2;
  localparam int unsigned CountBits  = 32;

  // The clearing pass walks the larger of the two table depths.
  localparam int unsigned ClrIdxBits = (CtrIdxBits > LocIdxBits) ? CtrIdxBits : LocIdxBits;

  // Result queue behind the pipeline.
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrBits = 2;
  localparam int unsigned FifoCntBits = 3;

  typedef logic [CountBits-1:0] count_t;
  typedef logic [CtrBits-1:0]   ctr_t;

  localparam count_t CountMax = '1;
  localparam ctr_t   CtrMax   = '1;
  localparam ctr_t   CtrMin   = '0;

  typedef struct packed {
    logic [AddrBits-1:0] branch_address;
    logic                taken;
  } req_t;

  typedef struct packed {
    logic                    pred_bimodal;
    logic                    pred_local;
    logic                    pred_global;
    logic                    pred_gshare;
    logic                    pred_local_xor;
    logic [OutCountBits-1:0] total_branches;
    logic [OutCountBits-1:0] total_miss_bimodal;
    logic [OutCountBits-1:0] total_miss_local;
    logic [OutCountBits-1:0] total_miss_global;
    logic [OutCountBits-1:0] total_miss_gshare;
    logic [OutCountBits-1:0] total_miss_local_xor;
  } rsp_t;

  // Table clearing sweep after reset.
  typedef struct packed {
    logic                  active;
    logic [ClrIdxBits-1:0] idx;
  } clr_t;

  // Counter lookup issued to a predictor lane.
  typedef struct packed {
    logic                  valid;
    logic [CtrIdxBits-1:0] idx;
    logic                  taken;
  } lookup_t;

  // Standard 2-bit saturating counter training.
  function automatic ctr_t ctr_next(input ctr_t ctr, input logic taken);
    ctr_t res;
    res = ctr;
    if (taken) begin
      if (ctr != CtrMax) res = ctr + ctr_t'(1);
    end else begin
      if (ctr != CtrMin) res = ctr - ctr_t'(1);
    end
    return res;
  endfunction

  function automatic count_t sat_inc(input count_t cnt);
    count_t res;
    res = cnt;
    if (cnt != CountMax) res = cnt + count_t'(1);
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bdp_ram.sv =====
`default_nettype none

module bdp_ram #(
  parameter int unsigned Width    = 2,
  parameter int unsigned AddrBits = 10
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic                re_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [2**AddrBits];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read returns the contents before a write at the same edge.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bdp_lane.sv =====
`default_nettype none

module bdp_lane (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bdp_pkg::clr_t    clr_i,
  input  wire bdp_pkg::lookup_t lookup_i,
  output logic                  pred_o,
  output bdp_pkg::count_t       miss_count_o
);

  logic                           s2_valid_q;
  logic [bdp_pkg::CtrIdxBits-1:0] s2_idx_q;
  logic                           s2_taken_q;

  logic                           fwd_valid_q;
  logic [bdp_pkg::CtrIdxBits-1:0] fwd_idx_q;
  bdp_pkg::ctr_t                  fwd_ctr_q;

  bdp_pkg::count_t miss_q, miss_d;

  bdp_pkg::ctr_t                  ram_rdata;
  bdp_pkg::ctr_t                  ctr_cur;
  bdp_pkg::ctr_t                  ctr_new;
  logic                           ram_we;
  logic [bdp_pkg::CtrIdxBits-1:0] ram_waddr;
  bdp_pkg::ctr_t                  ram_wdata;

  bdp_ram #(
    .Width    (bdp_pkg::CtrBits),
    .AddrBits (bdp_pkg::CtrIdxBits)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (lookup_i.valid),
    .raddr_i (lookup_i.idx),
    .rdata_o (ram_rdata)
  );

  // The write of the previous branch lands on the same edge as our read,
  // so its value is taken from the bypass register instead.
  always_comb begin
    ctr_cur = ram_rdata;
    if (fwd_valid_q && (fwd_idx_q == s2_idx_q)) ctr_cur = fwd_ctr_q;
  end

  assign ctr_new = bdp_pkg::ctr_next(ctr_cur, s2_taken_q);
  assign pred_o  = ctr_cur[bdp_pkg::CtrBits-1];

  always_comb begin
    miss_d = miss_q;
    if (s2_valid_q && (pred_o != s2_taken_q)) miss_d = bdp_pkg::sat_inc(miss_q);
  end

  assign miss_count_o = miss_d;

  always_comb begin
    ram_we    = clr_i.active || s2_valid_q;
    ram_waddr = s2_idx_q;
    ram_wdata = ctr_new;
    if (clr_i.active) begin
      ram_waddr = clr_i.idx[bdp_pkg::CtrIdxBits-1:0];
      ram_wdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      miss_q      <= '0;
    end else begin
      s2_valid_q  <= lookup_i.valid;
      fwd_valid_q <= s2_valid_q;
      miss_q      <= miss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup_i.valid) begin
      s2_idx_q   <= lookup_i.idx;
      s2_taken_q <= lookup_i.taken;
    end
    fwd_idx_q <= s2_idx_q;
    fwd_ctr_q <= ctr_new;
  end

endmodule

`default_nettype wire

// ===== rtl/bdp_out_fifo.sv =====
`default_nettype none

module bdp_out_fifo (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push_i,
  input  wire bdp_pkg::rsp_t                   push_data_i,
  input  wire logic                            pop_i,
  output logic                                 valid_o,
  output bdp_pkg::rsp_t                        data_o,
  output logic [bdp_pkg::FifoCntBits-1:0]      count_o
);

  bdp_pkg::rsp_t                   mem_q [bdp_pkg::FifoDepth];
  logic [bdp_pkg::FifoPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [bdp_pkg::FifoCntBits-1:0] cnt_q, cnt_d;
  logic                            pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;
  assign pop     = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) cnt_d = cnt_q + 1'b1;
    if (!push_i && pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)    rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/branch_direction_predictor_set.sv =====
// Channel   Direction  Handshake                 Payload
// request   in         req_valid_i / req_ready_o  req_i (bdp_pkg::req_t)
// response  out        rsp_valid_o / rsp_ready_i  rsp_o (bdp_pkg::rsp_t)
//
// One request is taken per cycle, limited by one lookup and one write-back
// per table each cycle; its response passes the s1 and s2 registers, then
// enters the result queue. After reset a clearing pass zeroes the tables,
// one entry per cycle over 1024 entries, and holds off requests until it ends.
// A stalled response waits in a four-entry queue; requests keep flowing
// until the queue together with the pipeline holds four branches.
`default_nettype none

module branch_direction_predictor_set (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire bdp_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i,
  output bdp_pkg::rsp_t      rsp_o
);

  // The pipeline has three steps. On the accepting edge the local history
  // table is read and the global history register advances. In the next
  // cycle the local history is known, so the five counter tables are read.
  // In the last step each lane predicts, trains its counter and writes
  // it back, the counts advance and the response enters the queue.
  // Each table read may coincide with the write of the branch just ahead,
  // and a bypass register supplies that value.

  logic                           clr_active_q;
  logic [bdp_pkg::ClrIdxBits-1:0] clr_idx_q;
  bdp_pkg::clr_t                  clr;

  logic                           req_accept;
  logic [bdp_pkg::HistBits-1:0]   gh_q;

  logic                           s1_valid_q;
  logic [bdp_pkg::AddrBits-1:0]   s1_addr_q;
  logic                           s1_taken_q;
  logic [bdp_pkg::HistBits-1:0]   s1_gh_q;
  logic [bdp_pkg::LocIdxBits-1:0] s1_lidx;

  logic                           hfw_valid_q;
  logic [bdp_pkg::LocIdxBits-1:0] hfw_idx_q;
  logic [bdp_pkg::HistBits-1:0]   hfw_val_q;

  logic [bdp_pkg::HistBits-1:0]   hist_rdata;
  logic [bdp_pkg::HistBits-1:0]   lh;
  logic [bdp_pkg::HistBits-1:0]   lh_new;
  logic                           hist_we;
  logic [bdp_pkg::LocIdxBits-1:0] hist_waddr;
  logic [bdp_pkg::HistBits-1:0]   hist_wdata;

  logic [bdp_pkg::AddrBits-1:0]   lh_ext;
  logic [bdp_pkg::AddrBits-1:0]   gh_ext;
  logic [bdp_pkg::AddrBits-1:0]   gsh_hash;
  logic [bdp_pkg::AddrBits-1:0]   lxor_hash;

  bdp_pkg::lookup_t               lk_bim, lk_loc, lk_glb, lk_gsh, lk_lxor;
  logic                           pred_bim, pred_loc, pred_glb, pred_gsh, pred_lxor;
  bdp_pkg::count_t                miss_bim, miss_loc, miss_glb, miss_gsh, miss_lxor;

  logic                           s2_valid_q;
  bdp_pkg::count_t                branches_q, branches_d;
  bdp_pkg::rsp_t                  push_data;
  logic [bdp_pkg::FifoCntBits-1:0] fifo_cnt;
  logic [bdp_pkg::FifoCntBits:0]  occupancy;

  // Clearing pass over all tables after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_idx_q    <= '0;
    end else if (clr_active_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == '1) clr_active_q <= 1'b0;
    end
  end

  assign clr.active = clr_active_q;
  assign clr.idx    = clr_idx_q;

  // A request is taken only when every branch already inside the block
  // still has a place in the result queue.
  assign occupancy = {1'b0, fifo_cnt}
                   + (bdp_pkg::FifoCntBits+1)'(s1_valid_q)
                   + (bdp_pkg::FifoCntBits+1)'(s2_valid_q);
  assign req_ready_o = !clr_active_q
                    && (occupancy < (bdp_pkg::FifoCntBits+1)'(bdp_pkg::FifoDepth));
  assign req_accept  = req_valid_i && req_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gh_q        <= '0;
      s1_valid_q  <= 1'b0;
      hfw_valid_q <= 1'b0;
      s2_valid_q  <= 1'b0;
      branches_q  <= '0;
    end else begin
      if (req_accept) gh_q <= {gh_q[bdp_pkg::HistBits-2:0], req_i.taken};
      s1_valid_q  <= req_accept;
      hfw_valid_q <= s1_valid_q;
      s2_valid_q  <= s1_valid_q;
      branches_q  <= branches_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      s1_addr_q  <= req_i.branch_address;
      s1_taken_q <= req_i.taken;
      s1_gh_q    <= gh_q;
    end
    hfw_idx_q <= s1_lidx;
    hfw_val_q <= lh_new;
  end

  // Local history table.
  bdp_ram #(
    .Width    (bdp_pkg::HistBits),
    .AddrBits (bdp_pkg::LocIdxBits)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (req_accept),
    .raddr_i (req_i.branch_address[bdp_pkg::LocIdxBits-1:0]),
    .rdata_o (hist_rdata)
  );

  assign s1_lidx = s1_addr_q[bdp_pkg::LocIdxBits-1:0];

  always_comb begin
    lh = hist_rdata;
    if (hfw_valid_q && (hfw_idx_q == s1_lidx)) lh = hfw_val_q;
  end

  // The history shifts its own value, then takes the outcome as new low bit.
  assign lh_new = {lh[bdp_pkg::HistBits-2:0], s1_taken_q};

  always_comb begin
    hist_we    = clr_active_q || s1_valid_q;
    hist_waddr = s1_lidx;
    hist_wdata = lh_new;
    if (clr_active_q) begin
      hist_waddr = clr_idx_q[bdp_pkg::LocIdxBits-1:0];
      hist_wdata = '0;
    end
  end

  // Counter indices. The hashes use the whole address before the index
  // bits are kept.
  assign lh_ext    = bdp_pkg::AddrBits'(lh);
  assign gh_ext    = bdp_pkg::AddrBits'(s1_gh_q);
  assign gsh_hash  = gh_ext ^ s1_addr_q;
  assign lxor_hash = lh_ext ^ s1_addr_q;

  assign lk_bim  = '{valid: s1_valid_q, taken: s1_taken_q,
                     idx: s1_addr_q[bdp_pkg::CtrIdxBits-1:0]};
  assign lk_loc  = '{valid: s1_valid_q, taken: s1_taken_q,
                     idx: lh_ext[bdp_pkg::CtrIdxBits-1:0]};
  assign lk_glb  = '{valid: s1_valid_q, taken: s1_taken_q,
                     idx: gh_ext[bdp_pkg::CtrIdxBits-1:0]};
  assign lk_gsh  = '{valid: s1_valid_q, taken: s1_taken_q,
                     idx: gsh_hash[bdp_pkg::CtrIdxBits-1:0]};
  assign lk_lxor = '{valid: s1_valid_q, taken: s1_taken_q,
                     idx: lxor_hash[bdp_pkg::CtrIdxBits-1:0]};

  bdp_lane u_lane_bimodal (
    .clk_i (clk_i), .rst_ni (rst_ni), .clr_i (clr), .lookup_i (lk_bim),
    .pred_o (pred_bim), .miss_count_o (miss_bim)
  );

  bdp_lane u_lane_local (
    .clk_i (clk_i), .rst_ni (rst_ni), .clr_i (clr), .lookup_i (lk_loc),
    .pred_o (pred_loc), .miss_count_o (miss_loc)
  );

  bdp_lane u_lane_global (
    .clk_i (clk_i), .rst_ni (rst_ni), .clr_i (clr), .lookup_i (lk_glb),
    .pred_o (pred_glb), .miss_count_o (miss_glb)
  );

  bdp_lane u_lane_gshare (
    .clk_i (clk_i), .rst_ni (rst_ni), .clr_i (clr), .lookup_i (lk_gsh),
    .pred_o (pred_gsh), .miss_count_o (miss_gsh)
  );

  bdp_lane u_lane_local_xor (
    .clk_i (clk_i), .rst_ni (rst_ni), .clr_i (clr), .lookup_i (lk_lxor),
    .pred_o (pred_lxor), .miss_count_o (miss_lxor)
  );

  // The branch count includes the branch being reported.
  always_comb begin
    branches_d = branches_q;
    if (s2_valid_q) branches_d = bdp_pkg::sat_inc(branches_q);
  end

  always_comb begin
    push_data.pred_bimodal         = pred_bim;
    push_data.pred_local           = pred_loc;
    push_data.pred_global          = pred_glb;
    push_data.pred_gshare          = pred_gsh;
    push_data.pred_local_xor       = pred_lxor;
    push_data.total_branches       = branches_d[bdp_pkg::OutCountBits-1:0];
    push_data.total_miss_bimodal   = miss_bim[bdp_pkg::OutCountBits-1:0];
    push_data.total_miss_local     = miss_loc[bdp_pkg::OutCountBits-1:0];
    push_data.total_miss_global    = miss_glb[bdp_pkg::OutCountBits-1:0];
    push_data.total_miss_gshare    = miss_gsh[bdp_pkg::OutCountBits-1:0];
    push_data.total_miss_local_xor = miss_lxor[bdp_pkg::OutCountBits-1:0];
  end

  bdp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_valid_q),
    .push_data_i (push_data),
    .pop_i       (rsp_ready_i),
    .valid_o     (rsp_valid_o),
    .data_o      (rsp_o),
    .count_o     (fifo_cnt)
  );

endmodule

`default_nettype wire

// ===== rtl/bdp_checker.sv =====
`default_nettype none

module bdp_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          req_valid_i,
  input wire logic          req_ready_o,
  input wire logic          rsp_valid_o,
  input wire logic          rsp_ready_i,
  input wire bdp_pkg::rsp_t rsp_o
);

  logic                                  in_acc, out_acc;
  logic [bdp_pkg::FifoCntBits-1:0]       pend_q, pend_d;
  logic                                  have_last_q;
  logic [bdp_pkg::OutCountBits-1:0]      last_tb_q;

  assign in_acc  = req_valid_i && req_ready_o;
  assign out_acc = rsp_valid_o && rsp_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) pend_d = pend_q + 1'b1;
    if (!in_acc && out_acc) pend_d = pend_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      have_last_q <= 1'b0;
      last_tb_q   <= '0;
    end else begin
      pend_q <= pend_d;
      if (out_acc) begin
        have_last_q <= 1'b1;
        last_tb_q   <= rsp_o.total_branches;
      end
    end
  end

  // Every response answers a request that was taken earlier.
  a_rsp_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (pend_q != '0))
    else $error("response without an outstanding request");

  // Responses arrive in order, each counting one more branch.
  a_branch_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && have_last_q) |->
      ((rsp_o.total_branches == last_tb_q + 1'b1)
       || ((last_tb_q == '1) && (rsp_o.total_branches == '1))))
    else $error("branch count did not advance by one");

  // No predictor can miss more often than branches were seen.
  a_miss_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |->
      ((rsp_o.total_miss_bimodal <= rsp_o.total_branches)
       && (rsp_o.total_miss_local <= rsp_o.total_branches)
       && (rsp_o.total_miss_global <= rsp_o.total_branches)
       && (rsp_o.total_miss_gshare <= rsp_o.total_branches)
       && (rsp_o.total_miss_local_xor <= rsp_o.total_branches)))
    else $error("miss count exceeds branch count");

  a_rsp_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> rsp_valid_o)
    else $error("response valid dropped while stalled");

  a_rsp_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> $stable(rsp_o))
    else $error("response payload changed while stalled");

endmodule

bind branch_direction_predictor_set bdp_checker u_bdp_checker (.*);

`default_nettype wire

// ===== test/branch_direction_predictor_set_tb.sv =====
`timescale 1ns / 100ps

module branch_direction_predictor_set_tb;

  // Predictor lanes, in the order in which the response reports them.
  typedef enum int {
    PredBimodal,
    PredLocal,
    PredGlobal,
    PredGshare,
    PredLocalXor
  } lane_e;

  localparam int NumLanes = 5;
  localparam int NumCtrs = 1 << bdp_pkg::CtrIdxBits;
  localparam int NumSlots = 1 << bdp_pkg::LocIdxBits;

  // Pacing phases: none, sender idle, receiver stalling, both.
  localparam int NumPhases = 4;
  localparam int SendIdlePct [NumPhases] = '{0, 85, 0, 31};
  localparam int StallPct [NumPhases] = '{0, 0, 85, 31};
  localparam int RandomPerPhase = 375;

  // The limit leaves a wide margin over the clearing pass and over the
  // random run at its slowest.
  localparam int unsigned CycleLimit = 300000;
  localparam int DrainCycles = 12;

  // Branches that repeat with a short outcome pattern, so that the
  // history-based predictors have something to learn.
  localparam int PoolSize = 8;
  localparam int MaxPatLen = 12;

  // A row of the directed table. Where typed is set, want holds the
  // response as it can be worked out by hand; otherwise the predictor
  // supplies the expectation.
  typedef struct packed {
    bdp_pkg::req_t req;
    logic          typed;
    bdp_pkg::rsp_t want;
  } dir_row_t;

  localparam int NumDirected = 20;
  localparam dir_row_t Directed [NumDirected] = '{
    // First branch after reset: every counter is strongly not taken, so
    // a taken branch is a miss for all five predictors.
    '{'{32'h0000_0000, 1'b1}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1}},
    // All-ones address, not taken: every lane still predicts not taken,
    // so no miss is added.
    '{'{32'hFFFF_FFFF, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd2, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1}},
    // Drive one bimodal counter up into saturation.
    '{'{32'h0000_0000, 1'b1}, 1'b0, '0},
    '{'{32'h0000_0000, 1'b1}, 1'b0, '0},
    '{'{32'h0000_0000, 1'b1}, 1'b0, '0},
    '{'{32'h0000_0000, 1'b1}, 1'b0, '0},
    // Same low bits, upper bits set: must share the entries of address 0.
    '{'{32'hFFFF_FC00, 1'b1}, 1'b0, '0},
    '{'{32'hFFFF_FC00, 1'b0}, 1'b0, '0},
    '{'{32'hFFFF_FC00, 1'b0}, 1'b0, '0},
    '{'{32'hFFFF_FC00, 1'b0}, 1'b0, '0},
    // Address 0 again, not taken, with its counter already at the floor.
    '{'{32'h0000_0000, 1'b0}, 1'b0, '0},
    '{'{32'h0000_0000, 1'b0}, 1'b0, '0},
    '{'{32'h8000_0000, 1'b0}, 1'b0, '0},
    '{'{32'hAAAA_AAAA, 1'b1}, 1'b0, '0},
    '{'{32'h5555_5555, 1'b0}, 1'b0, '0},
    '{'{32'h0000_03FF, 1'b1}, 1'b0, '0},
    '{'{32'h7FFF_FFFF, 1'b1}, 1'b0, '0},
    '{'{32'h0000_0400, 1'b1}, 1'b0, '0},
    '{'{32'h1234_5678, 1'b1}, 1'b0, '0},
    '{'{32'h1234_5678, 1'b0}, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  bdp_pkg::req_t req_i = '0;
  logic rsp_ready_i = 1'b0;
  logic req_ready_o;
  logic rsp_valid_o;
  bdp_pkg::rsp_t rsp_o;

  branch_direction_predictor_set DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  // Our own copy of the predictor state.
  logic [bdp_pkg::CtrBits-1:0] ctr_tab [NumLanes][NumCtrs];
  logic [bdp_pkg::HistBits-1:0] local_hist [NumSlots];
  logic [bdp_pkg::HistBits-1:0] global_hist;
  bdp_pkg::count_t branch_total;
  bdp_pkg::count_t miss_total [NumLanes];

  // Responses still owed by the block, oldest first.
  bdp_pkg::rsp_t awaited_results [$];

  // Repeating branches used by the random part.
  logic [bdp_pkg::AddrBits-1:0] pool_addr [PoolSize];
  logic [MaxPatLen-1:0] pool_pat [PoolSize];
  int pool_len [PoolSize];
  int pool_pos [PoolSize];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int results_checked = 0;
  int branches_sent = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Reset is held low at the start and released once.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Work out the response to one resolved branch and train the tables.
  // Each lane's prediction is read before its own counter moves.
  function automatic bdp_pkg::rsp_t predict_branch(input bdp_pkg::req_t br);
    logic [bdp_pkg::LocIdxBits-1:0] slot;
    logic [bdp_pkg::HistBits-1:0] own_hist;
    logic [bdp_pkg::CtrIdxBits-1:0] low_addr;
    logic [bdp_pkg::CtrIdxBits-1:0] idx [NumLanes];
    logic [NumLanes-1:0] guess;
    bdp_pkg::rsp_t res;
    slot = br.branch_address[bdp_pkg::LocIdxBits-1:0];
    low_addr = br.branch_address[bdp_pkg::CtrIdxBits-1:0];
    own_hist = local_hist[slot];
    idx[PredBimodal] = low_addr;
    idx[PredLocal] = bdp_pkg::CtrIdxBits'(own_hist);
    idx[PredGlobal] = bdp_pkg::CtrIdxBits'(global_hist);
    idx[PredGshare] = bdp_pkg::CtrIdxBits'(global_hist) ^ low_addr;
    idx[PredLocalXor] = bdp_pkg::CtrIdxBits'(own_hist) ^ low_addr;
    if (branch_total != bdp_pkg::CountMax) branch_total = branch_total + 1'b1;
    for (int p = 0; p < NumLanes; p++) begin
      guess[p] = ctr_tab[p][idx[p]][bdp_pkg::CtrBits-1];
      if (guess[p] != br.taken && miss_total[p] != bdp_pkg::CountMax) begin
        miss_total[p] = miss_total[p] + 1'b1;
      end
      if (br.taken) begin
        if (ctr_tab[p][idx[p]] != bdp_pkg::CtrMax) begin
          ctr_tab[p][idx[p]] = ctr_tab[p][idx[p]] + 1'b1;
        end
      end else begin
        if (ctr_tab[p][idx[p]] != bdp_pkg::CtrMin) begin
          ctr_tab[p][idx[p]] = ctr_tab[p][idx[p]] - 1'b1;
        end
      end
    end
    local_hist[slot] = {own_hist[bdp_pkg::HistBits-2:0], br.taken};
    global_hist = {global_hist[bdp_pkg::HistBits-2:0], br.taken};
    res.pred_bimodal = guess[PredBimodal];
    res.pred_local = guess[PredLocal];
    res.pred_global = guess[PredGlobal];
    res.pred_gshare = guess[PredGshare];
    res.pred_local_xor = guess[PredLocalXor];
    res.total_branches = branch_total[bdp_pkg::OutCountBits-1:0];
    res.total_miss_bimodal = miss_total[PredBimodal][bdp_pkg::OutCountBits-1:0];
    res.total_miss_local = miss_total[PredLocal][bdp_pkg::OutCountBits-1:0];
    res.total_miss_global = miss_total[PredGlobal][bdp_pkg::OutCountBits-1:0];
    res.total_miss_gshare = miss_total[PredGshare][bdp_pkg::OutCountBits-1:0];
    res.total_miss_local_xor = miss_total[PredLocalXor][bdp_pkg::OutCountBits-1:0];
    return res;
  endfunction

  // Give pool entry k a fresh address and outcome pattern. Half of the
  // patterns look like a loop: taken every time but the last. Some entries
  // share their low bits with the previous one, so they alias in the tables.
  function automatic void fill_pool_entry(input int k);
    pool_addr[k] = $urandom;
    if (k > 0 && $urandom_range(3) == 0) begin
      pool_addr[k][bdp_pkg::CtrIdxBits-1:0] = pool_addr[k-1][bdp_pkg::CtrIdxBits-1:0];
    end
    pool_len[k] = $urandom_range(MaxPatLen, 1);
    if ($urandom_range(1) == 1) begin
      pool_pat[k] = '1;
      pool_pat[k][pool_len[k]-1] = 1'b0;
    end else begin
      pool_pat[k] = MaxPatLen'($urandom);
    end
    pool_pos[k] = 0;
  endfunction

  // Mostly branches from the pool following their patterns; the rest is
  // noise with any address and outcome.
  function automatic bdp_pkg::req_t draw_branch();
    bdp_pkg::req_t res;
    int k;
    if ($urandom_range(99) < 20) begin
      res.branch_address = $urandom;
      res.taken = 1'($urandom_range(1));
    end else begin
      k = $urandom_range(PoolSize - 1);
      res.branch_address = pool_addr[k];
      res.taken = pool_pat[k][pool_pos[k]];
      pool_pos[k] = (pool_pos[k] + 1) % pool_len[k];
      if ($urandom_range(63) == 0) fill_pool_entry(k);
    end
    return res;
  endfunction

  // Offer one request and hold it until the block takes it. The sender
  // may first go idle for a random number of cycles; when it does not,
  // valid stays high straight into the next request.
  task automatic send_branch(input bdp_pkg::req_t br, input logic typed,
                             input bdp_pkg::rsp_t typed_want);
    bdp_pkg::rsp_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid_i <= 1'b1;
    req_i <= br;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    // Accepted at this edge: the predictor still has to run so that its
    // state follows the block even where the row gives the answer.
    predicted = predict_branch(br);
    awaited_results.push_back(typed ? typed_want : predicted);
    branches_sent++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // The receiver drops ready at random according to the current phase.
  always @(posedge clk_i) begin
    rsp_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Every accepted response is compared with the oldest expectation.
  always @(posedge clk_i) begin
    bdp_pkg::rsp_t want;
    if (rsp_valid_o === 1'b1 && rsp_ready_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: response with no branch outstanding, expected none, got %h",
                 $time, rsp_o);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("pred_bimodal", 32'(want.pred_bimodal), 32'(rsp_o.pred_bimodal));
        check_field("pred_local", 32'(want.pred_local), 32'(rsp_o.pred_local));
        check_field("pred_global", 32'(want.pred_global), 32'(rsp_o.pred_global));
        check_field("pred_gshare", 32'(want.pred_gshare), 32'(rsp_o.pred_gshare));
        check_field("pred_local_xor", 32'(want.pred_local_xor), 32'(rsp_o.pred_local_xor));
        check_field("total_branches", want.total_branches, rsp_o.total_branches);
        check_field("total_miss_bimodal", want.total_miss_bimodal, rsp_o.total_miss_bimodal);
        check_field("total_miss_local", want.total_miss_local, rsp_o.total_miss_local);
        check_field("total_miss_global", want.total_miss_global, rsp_o.total_miss_global);
        check_field("total_miss_gshare", want.total_miss_gshare, rsp_o.total_miss_gshare);
        check_field("total_miss_local_xor", want.total_miss_local_xor,
                    rsp_o.total_miss_local_xor);
        results_checked++;
      end
    end
  end

  // Watchdog: a stuck handshake or a response that never comes ends here.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timed out with %0d responses still owed.", awaited_results.size());
    $display("branch_direction_predictor_set: mismatch");
    $finish;
  end

  initial begin : stimulus
    for (int p = 0; p < NumLanes; p++) begin
      for (int i = 0; i < NumCtrs; i++) ctr_tab[p][i] = bdp_pkg::CtrMin;
      miss_total[p] = '0;
    end
    for (int i = 0; i < NumSlots; i++) local_hist[i] = '0;
    global_hist = '0;
    branch_total = '0;

    // The block itself holds off requests during its clearing pass, so we
    // simply start offering once reset is released.
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      send_idle_pct = SendIdlePct[ph];
      stall_pct = StallPct[ph];
      for (int k = 0; k < PoolSize; k++) fill_pool_entry(k);
      if (ph == 0) begin
        for (int r = 0; r < NumDirected; r++) begin
          send_branch(Directed[r].req, Directed[r].typed, Directed[r].want);
        end
      end
      for (int n = 0; n < RandomPerPhase; n++) send_branch(draw_branch(), 1'b0, '0);
    end
    req_valid_i <= 1'b0;

    // Let every owed response arrive, then watch a little longer for
    // anything extra.
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d branches (%0d directed, the rest patterned and random) over four",
             branches_sent, NumDirected);
    $display("pacing phases; %0d responses compared, %0d field errors.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("branch_direction_predictor_set: match");
    end else begin
      $display("branch_direction_predictor_set: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bdp_pkg.sv
rtl/bdp_ram.sv
rtl/bdp_lane.sv
rtl/bdp_out_fifo.sv
rtl/branch_direction_predictor_set.sv
rtl/bdp_checker.sv
test/branch_direction_predictor_set_tb.sv
